>>> rtl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Shared types, constants and a helper function for the 3x3 RGB median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    // Pixel and window geometry.
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int PIX_W   = CH_W * NUM_CH;
    localparam int WIN_N   = 9;
    localparam int COORD_W = 12;
    localparam int DIM_W   = 13;

    // A value is the median when fewer than five values lie below it and at
    // least five lie at or below it.
    localparam int MED_RANK = 5;

    // Centre queue between the median pipeline and the result sequencer.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CREDIT_W   = $clog2(FIFO_DEPTH + 1);

    // Configuration reset values and limits.
    localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 13'd3840;
    localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 13'd2160;
    localparam logic [DIM_W-1:0] DIM_LIMIT        = 13'd4096;
    localparam logic [DIM_W-1:0] DIM_MIN          = 13'd3;

    // Register indexes on the configuration port.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0]            pixel_t;
    typedef logic [WIN_N-1:0][PIX_W-1:0] window_t;

    // Per-centre bookkeeping that travels beside the pixel data.
    typedef struct packed {
        logic               center;    // window complete, results follow
        logic               row_lo;    // centre row is 1: also write row 0
        logic               row_hi;    // centre row is H-2: also write row H-1
        logic               col_lo;    // centre column is 1: also write column 0
        logic               col_hi;    // centre column is W-2: also write W-1
        logic               frame_end; // last pixel of the frame
        logic [COORD_W-1:0] row_c;     // centre row
        logic [COORD_W-1:0] col_c;     // centre column
    } tag_t;

    typedef struct packed {
        tag_t   tag;
        pixel_t med;
    } centre_t;

    // Row and column phases of the border replication sequence.
    typedef enum logic [2:0] {
        PH_LO  = 3'b001,
        PH_MID = 3'b010,
        PH_HI  = 3'b100
    } phase_t;

    // Clamps a dimension to [3, hi] and returns the clamped value minus one.
    function automatic logic [COORD_W-1:0] dim_last(logic [DIM_W-1:0] v,
                                                    logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] t;
        if (v < DIM_MIN) begin
            t = DIM_MIN - 13'd1;
        end else if (v > hi) begin
            t = hi - 13'd1;
        end else begin
            t = v - 13'd1;
        end
        return t[COORD_W-1:0];
    endfunction

endpackage

>>> rtl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/mf3_median.sv
// ----------------------------------------------------------------------------
// mf3_median
// Two-stage rank-select median of the nine window values, per channel.
// ----------------------------------------------------------------------------
module mf3_median import mf3_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    input  tag_t    in_tag,
    input  window_t in_win,
    output logic    out_valid,
    output centre_t out_entry
);

    logic [NUM_CH-1:0][WIN_N-1:0] sel_next;
    logic [NUM_CH-1:0][WIN_N-1:0] sel_reg;
    window_t                      win_reg;
    tag_t                         tag_a_reg;
    logic                         valid_a_reg;
    pixel_t                       med_next;
    pixel_t                       med_reg;
    tag_t                         tag_b_reg;
    logic                         valid_b_reg;

    // Stage A: rank of every value among the nine, one flag per median hit.
    always_comb begin
        logic [3:0]      less_cnt;
        logic [3:0]      le_cnt;
        logic [CH_W-1:0] va;
        logic [CH_W-1:0] vb;
        sel_next = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            for (int a = 0; a < WIN_N; a++) begin
                less_cnt = '0;
                le_cnt   = '0;
                va       = in_win[a][c*CH_W +: CH_W];
                for (int b = 0; b < WIN_N; b++) begin
                    vb = in_win[b][c*CH_W +: CH_W];
                    less_cnt = less_cnt + {3'd0, (vb < va)};
                    le_cnt   = le_cnt + {3'd0, (vb <= va)};
                end
                sel_next[c][a] = (less_cnt <= 4'(MED_RANK - 1)) &&
                                 (le_cnt >= 4'(MED_RANK));
            end
        end
    end

    // Stage B: every flagged value equals the median, so an OR merges them.
    always_comb begin
        med_next = '0;
        for (int c = 0; c < NUM_CH; c++) begin
            for (int a = 0; a < WIN_N; a++) begin
                if (sel_reg[c][a]) begin
                    med_next[c*CH_W +: CH_W] = med_next[c*CH_W +: CH_W] |
                                               win_reg[a][c*CH_W +: CH_W];
                end
            end
        end
    end

    // Pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
        end else begin
            valid_a_reg <= in_valid;
            valid_b_reg <= valid_a_reg;
        end
    end

    // Pipeline payload.
    always_ff @(posedge aclk) begin
        sel_reg   <= sel_next;
        win_reg   <= in_win;
        tag_a_reg <= in_tag;
        med_reg   <= med_next;
        tag_b_reg <= tag_a_reg;
    end

    assign out_valid     = valid_b_reg;
    assign out_entry.tag = tag_b_reg;
    assign out_entry.med = med_reg;

    // Each complete window must flag at least one median candidate per
    // channel. Windows of border pixels may still hold undefined data.
    a_sel_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_a_reg && tag_a_reg.center) |-> ((sel_reg[0] != '0) &&
                                               (sel_reg[1] != '0) &&
                                               (sel_reg[2] != '0)))
        else $error("median stage found no candidate");

    // Every input item reaches the output through the stage A and stage B registers.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid |=> ##1 valid_b_reg)
        else $error("median pipeline lost an item");

endmodule

>>> rtl/mf3_emitter.sv
// ----------------------------------------------------------------------------
// mf3_emitter
// Centre queue and result sequencer: expands each centre into its one to
// nine border-replicated results and drives the output register.
// ----------------------------------------------------------------------------
module mf3_emitter import mf3_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  centre_t     in_entry,
    input  logic        m_tready,
    output logic        m_tvalid,
    output logic [47:0] m_tdata,   // out_row, out_col, med0, med1, med2
    output logic        m_tlast,   // run_last
    output logic [0:0]  m_tuser,   // frame_last
    output logic        retire
);

    centre_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg;
    logic [FIFO_AW-1:0]     rd_ptr_reg;
    logic [CREDIT_W-1:0]    cnt_reg;
    logic                   started_reg;
    phase_t                 rph_reg;
    phase_t                 cph_reg;
    logic                   valid_reg;
    logic [COORD_W-1:0]     row_reg;
    logic [COORD_W-1:0]     col_reg;
    pixel_t                 med_reg;
    logic                   last_reg;
    logic                   flast_reg;

    centre_t                head;
    logic                   push;
    logic                   pop;
    logic                   load;
    phase_t                 cur_r;
    phase_t                 cur_c;
    phase_t                 start_c;
    phase_t                 rph_next;
    phase_t                 cph_next;
    logic                   r_last;
    logic                   c_last;
    logic                   last;
    logic [COORD_W-1:0]     row_val;
    logic [COORD_W-1:0]     col_val;

    assign head = fifo_reg[rd_ptr_reg];
    assign push = in_valid && in_entry.tag.center;
    assign load = (cnt_reg != '0) && (!valid_reg || m_tready);
    assign pop  = load && last;

    // Current phases: a fresh head entry starts at its first row and column.
    assign start_c = head.tag.col_lo ? PH_LO : PH_MID;
    assign cur_r   = started_reg ? rph_reg : (head.tag.row_lo ? PH_LO : PH_MID);
    assign cur_c   = started_reg ? cph_reg : start_c;

    assign r_last = (cur_r == PH_HI) || ((cur_r == PH_MID) && !head.tag.row_hi);
    assign c_last = (cur_c == PH_HI) || ((cur_c == PH_MID) && !head.tag.col_hi);
    assign last   = r_last && c_last;

    // Coordinates of the result in the current phase.
    always_comb begin
        unique case (cur_r)
            PH_LO:   row_val = '0;
            PH_MID:  row_val = head.tag.row_c;
            PH_HI:   row_val = head.tag.row_c + 12'd1;
            default: row_val = '0;
        endcase
        unique case (cur_c)
            PH_LO:   col_val = '0;
            PH_MID:  col_val = head.tag.col_c;
            PH_HI:   col_val = head.tag.col_c + 12'd1;
            default: col_val = '0;
        endcase
    end

    // Columns advance first; at the end of a row the column phase restarts.
    always_comb begin
        if (c_last) begin
            cph_next = start_c;
            rph_next = (cur_r == PH_LO) ? PH_MID : PH_HI;
        end else begin
            cph_next = (cur_c == PH_LO) ? PH_MID : PH_HI;
            rph_next = cur_r;
        end
    end

    // Queue pointers, sequencer state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg  <= '0;
            rd_ptr_reg  <= '0;
            cnt_reg     <= '0;
            started_reg <= 1'b0;
            rph_reg     <= PH_MID;
            cph_reg     <= PH_MID;
            valid_reg   <= 1'b0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            cnt_reg <= cnt_reg + CREDIT_W'(push) - CREDIT_W'(pop);
            if (load) begin
                started_reg <= !last;
                rph_reg     <= rph_next;
                cph_reg     <= cph_next;
                valid_reg   <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Queue storage and output payload.
    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[wr_ptr_reg] <= in_entry;
        end
        if (load) begin
            row_reg   <= row_val;
            col_reg   <= col_val;
            med_reg   <= head.med;
            last_reg  <= last;
            flast_reg <= last && head.tag.frame_end;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = {med_reg, col_reg, row_reg};
    assign m_tlast    = last_reg;
    assign m_tuser[0] = flast_reg;
    assign retire     = pop;

    // The credit scheme upstream must keep the queue from overflowing.
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> ((cnt_reg < CREDIT_W'(FIFO_DEPTH)) || pop))
        else $error("centre queue overflow");

    // A centre is only retired from a non-empty queue.
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (cnt_reg != '0))
        else $error("centre queue underflow");

    // The frame's final result also closes its run.
    a_frame_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> m_tlast)
        else $error("frame end without run end");

endmodule

>>> rtl/median_filter_3x3_rgb.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_rgb
// 3x3 per-channel median filter for a raster-order stream of RGB pixels.
// ----------------------------------------------------------------------------
// The block takes one pixel per cycle on the slave stream and keeps the two
// previous rows in a single line-store RAM (upper and middle rows side by
// side, one read and one write per pixel). Once a pixel at row 2 or later and
// column 2 or later arrives, the window centred one row up and one column left
// is complete and its exact median is sent out, tagged with row and column.
// Border pixels copy their nearest filtered neighbor, so one centre gives one
// to nine results; results are therefore not in raster order. A centre passes
// s1, s2, median stages A and B, the queue and the output register. The
// sustained rate is one pixel per cycle while each centre makes one result
// and m_tready is high; a centre with several results holds the output until
// all are loaded, and input stalls once eight pixels are in flight, counted
// over the pipeline and the eight-entry centre queue until a pixel is dropped
// at the median or its last result is loaded for output. A configuration
// write restarts the frame at row 0, column 0; it must only be issued while
// the block is idle. The line store holds no defined data after reset, and
// no result depends on an entry not yet written in the current frame.
// ----------------------------------------------------------------------------
module median_filter_3x3_rgb import mf3_pkg::*; #(
    parameter int MAX_WIDTH = 4096
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input pixel stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // chan0, chan1, chan2
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_row, out_col, med0, med1, med2
    output logic        m_tlast,   // run_last
    output logic [0:0]  m_tuser,   // frame_last
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int               W_HI   = (MAX_WIDTH < 4096) ? MAX_WIDTH : 4096;
    localparam int               ADDR_W = $clog2(W_HI);
    localparam logic [DIM_W-1:0] W_HI13 = DIM_W'(W_HI);

    logic [DIM_W-1:0]    frame_width_reg;
    logic [DIM_W-1:0]    frame_height_reg;
    logic [COORD_W-1:0]  w_last_reg;
    logic [COORD_W-1:0]  h_last_reg;
    logic [COORD_W-1:0]  row_count_reg;
    logic [COORD_W-1:0]  col_count_reg;
    logic [COORD_W-1:0]  row_count_next;
    logic [COORD_W-1:0]  col_count_next;
    logic [CREDIT_W-1:0] credit_reg;
    logic [CREDIT_W-1:0] credit_next;

    logic                s1_valid_reg;
    pixel_t              s1_pix_reg;
    logic [ADDR_W-1:0]   s1_addr_reg;
    tag_t                s1_tag_reg;
    logic                s2_valid_reg;
    tag_t                s2_tag_reg;
    window_t             window_reg;

    logic                accept;
    logic                cfg_wr;
    tag_t                acc_tag;
    logic [2*PIX_W-1:0]  ram_rdata;
    logic [2*PIX_W-1:0]  ram_wdata;
    logic                med_valid;
    centre_t             med_entry;
    logic                drop;
    logic                retire;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign s_tready = credit_reg < CREDIT_W'(FIFO_DEPTH);
    assign accept   = s_tvalid && s_tready;

    // Register read-back.
    always_comb begin
        unique case (paddr[2])
            REG_FRAME_WIDTH:  prdata = {19'd0, frame_width_reg};
            REG_FRAME_HEIGHT: prdata = {19'd0, frame_height_reg};
            default:          prdata = '0;
        endcase
    end

    // Raster position of the next pixel.
    always_comb begin
        if (col_count_reg == w_last_reg) begin
            col_count_next = '0;
            row_count_next = (row_count_reg == h_last_reg) ? '0 :
                             row_count_reg + 12'd1;
        end else begin
            col_count_next = col_count_reg + 12'd1;
            row_count_next = row_count_reg;
        end
    end

    // Classify the accepted pixel: does it complete a window, and which
    // border rows and columns does that window's result also fill.
    always_comb begin
        acc_tag.center    = (row_count_reg >= 12'd2) && (col_count_reg >= 12'd2);
        acc_tag.row_lo    = (row_count_reg == 12'd2);
        acc_tag.row_hi    = (row_count_reg == h_last_reg);
        acc_tag.col_lo    = (col_count_reg == 12'd2);
        acc_tag.col_hi    = (col_count_reg == w_last_reg);
        acc_tag.frame_end = (row_count_reg == h_last_reg) &&
                            (col_count_reg == w_last_reg);
        acc_tag.row_c     = row_count_reg - 12'd1;
        acc_tag.col_c     = col_count_reg - 12'd1;
    end

    // Items in flight, from acceptance until dropped or last result loaded.
    assign drop        = med_valid && !med_entry.tag.center;
    assign credit_next = credit_reg + CREDIT_W'(accept) - CREDIT_W'(drop) -
                         CREDIT_W'(retire);

    // Configuration, counters and pipeline control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            w_last_reg       <= dim_last(FRAME_WIDTH_RST, W_HI13);
            h_last_reg       <= dim_last(FRAME_HEIGHT_RST, DIM_LIMIT);
            row_count_reg    <= '0;
            col_count_reg    <= '0;
            credit_reg       <= '0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
        end else begin
            credit_reg   <= credit_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_FRAME_WIDTH: begin
                        frame_width_reg <= pwdata[DIM_W-1:0];
                        w_last_reg      <= dim_last(pwdata[DIM_W-1:0], W_HI13);
                    end
                    REG_FRAME_HEIGHT: begin
                        frame_height_reg <= pwdata[DIM_W-1:0];
                        h_last_reg       <= dim_last(pwdata[DIM_W-1:0], DIM_LIMIT);
                    end
                    default: begin
                    end
                endcase
                row_count_reg <= '0;
                col_count_reg <= '0;
            end else if (accept) begin
                row_count_reg <= row_count_next;
                col_count_reg <= col_count_next;
            end
        end
    end

    // Line store: read at acceptance, write back in the next cycle. Addresses
    // of back-to-back pixels always differ since a row holds at least three.
    assign ram_wdata = {ram_rdata[PIX_W-1:0], s1_pix_reg};

    mf3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (W_HI)
    ) u_line_ram (
        .aclk  (aclk),
        .we    (s1_valid_reg),
        .waddr (s1_addr_reg),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (col_count_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // Pipeline payload and the window shift. Column 2 of the window takes
    // the upper row, middle row and new pixel.
    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_pix_reg  <= s_tdata;
            s1_addr_reg <= col_count_reg[ADDR_W-1:0];
            s1_tag_reg  <= acc_tag;
        end
        s2_tag_reg <= s1_tag_reg;
        if (s1_valid_reg) begin
            for (int k = 0; k < 3; k++) begin
                window_reg[k*3]     <= window_reg[k*3 + 1];
                window_reg[k*3 + 1] <= window_reg[k*3 + 2];
            end
            window_reg[2] <= ram_rdata[2*PIX_W-1:PIX_W];
            window_reg[5] <= ram_rdata[PIX_W-1:0];
            window_reg[8] <= s1_pix_reg;
        end
    end

    mf3_median u_median (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s2_valid_reg),
        .in_tag    (s2_tag_reg),
        .in_win    (window_reg),
        .out_valid (med_valid),
        .out_entry (med_entry)
    );

    mf3_emitter u_emitter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (med_valid),
        .in_entry (med_entry),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .retire   (retire)
    );

    // Items in flight never exceed the centre queue depth.
    a_credit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        credit_reg <= CREDIT_W'(FIFO_DEPTH))
        else $error("in-flight count exceeds queue depth");

    // Every accepted pixel writes the line store in the next cycle.
    a_writeback: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> s1_valid_reg)
        else $error("line store write-back missed");

    // The line store is never read and written at the same entry at once.
    a_no_collision: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s1_valid_reg) |-> (col_count_reg[ADDR_W-1:0] != s1_addr_reg))
        else $error("line store read/write collision");

endmodule
